// ===== sv/srbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbe_pkg
// Types and constants shared by the sensor ring bearing estimator.
// ----------------------------------------------------------------------------
package srbe_pkg;

	localparam int SAMPLE_BITS  = 10;
	localparam int RING_SIZE    = 12;
	localparam int IDX_BITS     = 4;
	localparam int BEARING_BITS = 9;
	localparam int NUM_BITS     = SAMPLE_BITS + 4;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = 2;
	localparam int QCNT_BITS    = 3;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(RING_SIZE - 1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] eye_0;
		logic [SAMPLE_BITS-1:0] eye_1;
		logic [SAMPLE_BITS-1:0] eye_2;
		logic [SAMPLE_BITS-1:0] eye_3;
		logic [SAMPLE_BITS-1:0] eye_4;
		logic [SAMPLE_BITS-1:0] eye_5;
		logic [SAMPLE_BITS-1:0] eye_6;
		logic [SAMPLE_BITS-1:0] eye_7;
		logic [SAMPLE_BITS-1:0] eye_8;
		logic [SAMPLE_BITS-1:0] eye_9;
		logic [SAMPLE_BITS-1:0] eye_10;
		logic [SAMPLE_BITS-1:0] eye_11;
	} ring_in_t;

	typedef struct packed {
		logic [BEARING_BITS-1:0] bearing;
		logic [IDX_BITS-1:0]     peak_index;
		logic [SAMPLE_BITS-1:0]  peak_value;
		logic                    flat_peak;
	} ring_out_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]    peak_index;
		logic [SAMPLE_BITS-1:0] peak_value;
		logic                   neg;
		logic [NUM_BITS-1:0]    num_mag;
		logic [SAMPLE_BITS-1:0] denom;
	} job_t;

	typedef struct packed {
		logic                 empty;
		logic [QCNT_BITS-1:0] count;
	} queue_status_t;

endpackage

// ===== sv/srbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbe_front
// Two-stage front end: finds the peak sensor, then forms the interpolation
// numerator and denominator from its ring neighbors.
// ----------------------------------------------------------------------------
module srbe_front
	import srbe_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ring_in_t      eyes,
	input  queue_status_t qstat,
	output logic          busy,
	output logic          push,
	output job_t          job
);

	typedef struct packed {
		logic [IDX_BITS-1:0]    idx;
		logic [SAMPLE_BITS-1:0] val;
	} cand_t;

	function automatic cand_t pick(input cand_t a, input cand_t b);
		cand_t r;
		r = (b.val > a.val) ? b : a;
		return r;
	endfunction

	logic [SAMPLE_BITS-1:0] eye_w [RING_SIZE];
	cand_t                  lvl1 [6];
	cand_t                  lvl2 [3];
	cand_t                  lvl3;
	cand_t                  best;
	logic                   accept;

	logic [SAMPLE_BITS-1:0] eye_s1 [RING_SIZE];
	logic [IDX_BITS-1:0]    idx_s1;
	logic [SAMPLE_BITS-1:0] peak_s1;
	logic                   v_s1;

	logic [SAMPLE_BITS-1:0] left_w;
	logic [SAMPLE_BITS-1:0] right_w;
	logic [SAMPLE_BITS-1:0] lo_w;
	logic [SAMPLE_BITS-1:0] mag_w;
	job_t                   job_s2;
	logic                   v_s2;
	logic [QCNT_BITS:0]     occupancy;

	assign eye_w[0]  = eyes.eye_0;
	assign eye_w[1]  = eyes.eye_1;
	assign eye_w[2]  = eyes.eye_2;
	assign eye_w[3]  = eyes.eye_3;
	assign eye_w[4]  = eyes.eye_4;
	assign eye_w[5]  = eyes.eye_5;
	assign eye_w[6]  = eyes.eye_6;
	assign eye_w[7]  = eyes.eye_7;
	assign eye_w[8]  = eyes.eye_8;
	assign eye_w[9]  = eyes.eye_9;
	assign eye_w[10] = eyes.eye_10;
	assign eye_w[11] = eyes.eye_11;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			lvl1[i] = pick('{idx: IDX_BITS'(2 * i), val: eye_w[2 * i]},
				'{idx: IDX_BITS'(2 * i + 1), val: eye_w[2 * i + 1]});
		end
		for (int i = 0; i < 3; i++) begin
			lvl2[i] = pick(lvl1[2 * i], lvl1[2 * i + 1]);
		end
		lvl3 = pick(lvl2[0], lvl2[1]);
		best = pick(lvl3, lvl2[2]);
	end

	// Every beat in flight has a reserved queue slot, so the stages never stall.
	assign occupancy = {1'b0, qstat.count} + (QCNT_BITS + 1)'(v_s1)
		+ (QCNT_BITS + 1)'(v_s2);
	assign busy   = occupancy >= (QCNT_BITS + 1)'(QUEUE_DEPTH);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eye_s1  <= eye_w;
			idx_s1  <= best.idx;
			peak_s1 <= best.val;
		end
	end

	always_comb begin
		left_w  = (idx_s1 == '0) ? eye_s1[RING_SIZE - 1] : eye_s1[idx_s1 - 1'b1];
		right_w = (idx_s1 == LAST_IDX) ? eye_s1[0] : eye_s1[idx_s1 + 1'b1];
		lo_w    = (left_w < right_w) ? left_w : right_w;
		mag_w   = (right_w < left_w) ? (left_w - right_w) : (right_w - left_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			job_s2.peak_index <= idx_s1;
			job_s2.peak_value <= peak_s1;
			job_s2.neg        <= right_w < left_w;
			job_s2.num_mag    <= ({4'b0, mag_w} << 4) - {4'b0, mag_w};
			job_s2.denom      <= peak_s1 - lo_w;
		end
	end

	assign push = v_s2;
	assign job  = job_s2;

endmodule

// ===== sv/srbe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbe_queue
// Four-entry queue of pending jobs between the front end and the divider.
// ----------------------------------------------------------------------------
module srbe_queue
	import srbe_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          wr_job,
	input  logic          pop,
	output job_t          rd_job,
	output queue_status_t qstat
);

	job_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	assign rd_job      = mem[rd_ptr_q];
	assign qstat.empty = count_q == '0;
	assign qstat.count = count_q;

endmodule

// ===== sv/srbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbe_back
// Back end: restoring divider for the peak offset and final bearing math.
// ----------------------------------------------------------------------------
module srbe_back
	import srbe_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t qstat,
	input  job_t          rd_job,
	output logic          pop,
	output logic          done,
	output ring_out_t     result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [1:0]              step_q;
	logic [NUM_BITS-1:0]     rem_q;
	logic [SAMPLE_BITS-1:0]  denom_q;
	logic [3:0]              quo_q;
	logic                    neg_q;
	logic                    flat_q;
	logic [IDX_BITS-1:0]     idx_q;
	logic [SAMPLE_BITS-1:0]  peak_q;
	logic                    done_q;
	ring_out_t               result_q;

	logic [NUM_BITS-1:0]     dshift_w;
	logic                    fits_w;
	logic [BEARING_BITS-1:0] base_w;
	logic [BEARING_BITS:0]   wide_w;
	logic [BEARING_BITS-1:0] bearing_w;

	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	always_comb begin
		dshift_w = {4'b0, denom_q} << step_q;
		fits_w   = rem_q >= dshift_w;
		base_w   = BEARING_BITS'(idx_q) * BEARING_BITS'(30);
		if (!neg_q) begin
			wide_w = {1'b0, base_w} + (BEARING_BITS + 1)'(quo_q);
		end else if ((BEARING_BITS)'(quo_q) > base_w) begin
			wide_w = {1'b0, base_w} + (BEARING_BITS + 1)'(360)
				- (BEARING_BITS + 1)'(quo_q);
		end else begin
			wide_w = {1'b0, base_w} - (BEARING_BITS + 1)'(quo_q);
		end
		bearing_w = wide_w[BEARING_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						state_q <= (rd_job.denom == '0) ? ST_FINISH : ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (step_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q   <= rd_job.num_mag;
				denom_q <= rd_job.denom;
				neg_q   <= rd_job.neg;
				flat_q  <= rd_job.denom == '0;
				idx_q   <= rd_job.peak_index;
				peak_q  <= rd_job.peak_value;
				quo_q   <= '0;
				step_q  <= 2'd3;
			end
			ST_DIVIDE: begin
				if (fits_w) begin
					rem_q         <= rem_q - dshift_w;
					quo_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			ST_FINISH: begin
				result_q.bearing    <= bearing_w;
				result_q.peak_index <= idx_q;
				result_q.peak_value <= peak_q;
				result_q.flat_peak  <= flat_q;
			end
			default: begin
				quo_q <= '0;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/sensor_ring_bearing_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_ring_bearing_estimator
// Bearing estimate from a twelve-sensor ring snapshot.
// ----------------------------------------------------------------------------
// A snapshot is taken at each clock edge where start is high and busy is low,
// one per cycle while the four-entry job queue has room. Each beat yields one
// result, shown for exactly one cycle with done high; the receiver cannot
// stall it. The front end is pipelined and never stalls. The back end takes
// one job at a time; its four-step restoring divider sets the sustained
// rate, and a flat peak skips the divide. An accepted beat passes through
// the front-end stages, the job queue and the back end's states to done.
// ----------------------------------------------------------------------------
module sensor_ring_bearing_estimator
	import srbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ring_in_t  eyes,
	output logic      done,
	output ring_out_t result
);

	logic          push;
	logic          pop;
	job_t          wr_job;
	job_t          rd_job;
	queue_status_t qstat;

	srbe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.eyes   (eyes),
		.qstat  (qstat),
		.busy   (busy),
		.push   (push),
		.job    (wr_job)
	);

	srbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.qstat  (qstat)
	);

	srbe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.rd_job (rd_job),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
